// File: hw/rtl/mnrf_pkg.sv
// Shared types and constants for the MIDI note repeat filter.
// Used by the controller, the datapath and the top level; depends on nothing.
package mnrf_pkg;

   // MIDI message types, taken from the high nibble of the status byte.
   localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
   localparam logic [3:0] MSG_NOTE_OFF = 4'h8;

   // Filter mode register.
   localparam int          MODE_WIDTH       = 2;
   localparam logic [1:0]  MODE_RESET       = 2'b10;
   localparam int          MODE_ON_BIT      = 0;
   localparam int          MODE_OFF_BIT     = 1;

   // What an accepted item does to its hold counter.
   typedef enum logic [1:0] {
      KIND_PRESS,
      KIND_RELEASE,
      KIND_OTHER
   } kind_type;

   // Controller to datapath.
   typedef struct packed {
      logic clear;   // write zero at the sweep address and advance it
      logic load;    // item accepted: capture it and read its counter
      logic exec;    // counter read data valid: update and write back
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic clear_done;
   } status_type;

endpackage

// File: hw/rtl/mnrf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mnrf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/mnrf_ctrl.sv
// Controller of the MIDI note repeat filter: clearing sweep, idle and execute.
// Depends on mnrf_pkg.
module mnrf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   output mnrf_pkg::cmd_type    cmd,
   input  mnrf_pkg::status_type status
);
   import mnrf_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      busy_in      = (state_in != ST_IDLE);
      rsp_valid_in = (state_ff == ST_EXEC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign cmd.clear = (state_ff == ST_CLEAR);
   assign cmd.load  = (state_ff == ST_IDLE) && start;
   assign cmd.exec  = (state_ff == ST_EXEC);
   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hw/rtl/mnrf_dpath.sv
// Datapath of the MIDI note repeat filter: message decode, hold counter
// memory, saturating update and mode register. Depends on mnrf_pkg, mnrf_ram.
module mnrf_dpath #(
   parameter int CHANNELS    = 16,
   parameter int PITCHES     = 128,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mnrf_pkg::cmd_type    cmd,
   output mnrf_pkg::status_type status,
   input  logic [7:0]           req_status_byte,
   input  logic [7:0]           req_note_byte,
   input  logic [7:0]           req_velocity_byte,
   input  logic                 csr_write_en,
   input  logic [1:0]           csr_write_data,
   output logic                 rsp_should_play
);
   import mnrf_pkg::*;

   localparam int DEPTH = CHANNELS * PITCHES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = '1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_ZERO = '0;
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE  = COUNT_WIDTH'(1);

   logic [MODE_WIDTH-1:0] mode_ff;
   logic [AW-1:0]         clr_addr_ff, clr_addr_in;
   logic [AW-1:0]         addr_ff;
   kind_type              kind_ff;
   logic                  in_range_ff;
   logic                  play_ff;

   logic [3:0]             chan;
   logic                   in_range;
   logic [AW-1:0]          addr;
   kind_type               kind;
   logic [COUNT_WIDTH-1:0] cur;
   logic [COUNT_WIDTH-1:0] next_count;
   logic                   update;
   logic                   play;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [COUNT_WIDTH-1:0] wr_data;

   // Decode of the item at the port, used in the cycle it is accepted.
   always_comb begin
      chan     = req_status_byte[3:0];
      in_range = (5'({1'b0, chan}) < 5'(CHANNELS)) &&
                 (9'({1'b0, req_note_byte}) < 9'(PITCHES));
      addr     = in_range ? AW'(int'(chan) * PITCHES + int'(req_note_byte)) : '0;
      if (req_status_byte[7:4] == MSG_NOTE_ON && req_velocity_byte != 8'd0 &&
          !req_velocity_byte[7]) begin
         kind = KIND_PRESS;
      end else if (req_status_byte[7:4] == MSG_NOTE_ON ||
                   req_status_byte[7:4] == MSG_NOTE_OFF) begin
         kind = KIND_RELEASE;
      end else begin
         kind = KIND_OTHER;
      end
   end

   // Counter update, in the cycle after the read was issued.
   always_comb begin
      next_count = cur;
      update     = 1'b0;
      play       = 1'b1;
      case (kind_ff)
         KIND_PRESS: begin
            update     = in_range_ff && (cur != COUNT_MAX);
            next_count = cur + COUNT_ONE;
            play       = update && (!mode_ff[MODE_ON_BIT] || cur == COUNT_ZERO);
         end
         KIND_RELEASE: begin
            update     = in_range_ff && (cur != COUNT_ZERO);
            next_count = cur - COUNT_ONE;
            play       = update && (!mode_ff[MODE_OFF_BIT] || cur == COUNT_ONE);
         end
         default: begin
            update = 1'b0;
            play   = 1'b1;
         end
      endcase
   end

   assign wr_en   = cmd.clear || (cmd.exec && update);
   assign wr_addr = cmd.clear ? clr_addr_ff : addr_ff;
   assign wr_data = cmd.clear ? COUNT_ZERO : next_count;

   mnrf_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (DEPTH)
   ) u_counts (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.load),
      .rd_addr (addr),
      .rd_data (cur)
   );

   assign clr_addr_in       = clr_addr_ff + AW'(1);
   assign status.clear_done = (clr_addr_ff == AW'(DEPTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_RESET;
         clr_addr_ff <= '0;
      end else begin
         if (csr_write_en) begin
            mode_ff <= csr_write_data;
         end
         if (cmd.clear) begin
            clr_addr_ff <= clr_addr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff     <= addr;
         kind_ff     <= kind;
         in_range_ff <= in_range;
      end
      if (cmd.exec) begin
         play_ff <= play;
      end
   end

   assign rsp_should_play = play_ff;

endmodule

// File: hw/rtl/midi_note_repeat_filter.sv
// Top level of the MIDI note repeat filter.
// Depends on mnrf_pkg, mnrf_ctrl, mnrf_dpath (and through it mnrf_ram).

// After reset the block sweeps its hold counter memory to zero, one counter a
// cycle, and holds busy high until all CHANNELS*PITCHES counters (2048 by
// default) are cleared; filter_mode may be written during the sweep. Each
// accepted item then goes through a read-modify-write of its counter in the
// synchronous memory: busy is high for one cycle after start is taken, and
// rsp_valid with rsp_should_play appears for one cycle in the following cycle,
// the same cycle in which the next item may already be accepted. The result
// cannot be held off, so the receiver must take it in that cycle.
module midi_note_repeat_filter #(
   parameter int CHANNELS    = 16,
   parameter int PITCHES     = 128,
   parameter int COUNT_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_status_byte,
   input  logic [7:0] req_note_byte,
   input  logic [7:0] req_velocity_byte,
   output logic       rsp_valid,
   output logic       rsp_should_play,
   input  logic       csr_write_en,
   input  logic [1:0] csr_write_data
);
   import mnrf_pkg::*;

   cmd_type    cmd;
   status_type status;

   mnrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   mnrf_dpath #(
      .CHANNELS    (CHANNELS),
      .PITCHES     (PITCHES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_status_byte   (req_status_byte),
      .req_note_byte     (req_note_byte),
      .req_velocity_byte (req_velocity_byte),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .rsp_should_play   (rsp_should_play)
   );

endmodule

// File: hw/rtl/mnrf_checker.sv
// Port-level timing checks for the MIDI note repeat filter, bound to the top.
// Depends on midi_note_repeat_filter.
module mnrf_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // The block is busy right after reset, while the counters are cleared.
   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("busy low right after reset");

   // An accepted item gets its result after the execute state, from the registered rsp_valid.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("accepted item produced no result");

   // No result without an item accepted ahead of the execute state that made it.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without an accepted item");

   // The block is busy for the cycle after an item is taken.
   a_busy_on_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // A result is shown while the block is ready for the next item.
   a_ready_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy high while a result is shown");

endmodule

bind midi_note_repeat_filter mnrf_checker u_mnrf_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

// File: verif/testbench.sv
// Self-checking testbench for the MIDI note repeat filter (midi_note_repeat_filter).
// Depends on mnrf_pkg and the block's RTL. It predicts each play decision from its own
// copy of the hold counters and checks it against every result.
`timescale 1ns / 1ps

module testbench;
   import mnrf_pkg::*;

   localparam int CHANNELS     = 16;
   localparam int PITCHES      = 128;
   localparam int COUNT_WIDTH  = 32;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int DRAIN_CYCLES = 4;

   typedef struct {
      logic [7:0] status;
      logic [7:0] note;
      logic [7:0] velocity;
      logic       should_play;
   } play_decision_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [7:0] req_status_byte = 8'h00;
   logic [7:0] req_note_byte = 8'h00;
   logic [7:0] req_velocity_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_should_play;
   logic       csr_write_en = 1'b0;
   logic [1:0] csr_write_data = 2'b00;

   logic [COUNT_WIDTH-1:0] held_notes [CHANNELS*PITCHES];
   logic [MODE_WIDTH-1:0]  filter_mode_copy;
   play_decision_type      pending_decisions [$];
   int                     mismatches = 0;
   int unsigned            cycle_count = 0;

   midi_note_repeat_filter #(
      .CHANNELS   (CHANNELS),
      .PITCHES    (PITCHES),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_status_byte  (req_status_byte),
      .req_note_byte    (req_note_byte),
      .req_velocity_byte(req_velocity_byte),
      .rsp_valid        (rsp_valid),
      .rsp_should_play  (rsp_should_play),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // A note-on with a velocity of zero or with the top bit set counts as a note-off.
   function automatic kind_type classify_message(logic [7:0] status, logic [7:0] velocity);
      if (status[7:4] == MSG_NOTE_ON && velocity != 8'd0 && !velocity[7])
         return KIND_PRESS;
      if (status[7:4] == MSG_NOTE_ON || status[7:4] == MSG_NOTE_OFF)
         return KIND_RELEASE;
      return KIND_OTHER;
   endfunction

   // Updates the held-note counts and returns whether the message is forwarded.
   function automatic logic decide_play(logic [7:0] status, logic [7:0] note,
                                        logic [7:0] velocity);
      kind_type kind;
      int       slot;
      logic     in_range;
      logic     play;
      kind = classify_message(status, velocity);
      in_range = (int'(status[3:0]) < CHANNELS) && (int'(note) < PITCHES);
      slot = int'(status[3:0]) * PITCHES + int'(note);
      play = 1'b0;
      case (kind)
         KIND_PRESS: begin
            if (in_range) begin
               if (held_notes[slot] != '1) begin
                  held_notes[slot] = held_notes[slot] + 1'b1;
                  play = filter_mode_copy[MODE_ON_BIT] ? (held_notes[slot] == 1) : 1'b1;
               end
            end
         end
         KIND_RELEASE: begin
            if (in_range) begin
               if (held_notes[slot] != '0) begin
                  held_notes[slot] = held_notes[slot] - 1'b1;
                  play = filter_mode_copy[MODE_OFF_BIT] ? (held_notes[slot] == 0) : 1'b1;
               end
            end
         end
         default: play = 1'b1;
      endcase
      return play;
   endfunction

   // Results are checked before the item accepted at the same edge is predicted.
   always @(posedge clock) begin
      play_decision_type want;
      play_decision_type taken;
      if (reset) begin
         foreach (held_notes[c]) held_notes[c] = '0;
         filter_mode_copy = MODE_RESET;
      end else begin
         if (rsp_valid === 1'b1) begin
            if (pending_decisions.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, got should_play %0b",
                        $time, rsp_should_play);
            end else begin
               want = pending_decisions.pop_front();
               if (rsp_should_play !== want.should_play) begin
                  mismatches++;
                  $display("%0t: status %02h note %02h velocity %02h: expected %0b, got %0b",
                           $time, want.status, want.note, want.velocity,
                           want.should_play, rsp_should_play);
               end
            end
         end
         if (csr_write_en)
            filter_mode_copy = csr_write_data;
         if (start && busy === 1'b0) begin
            taken.status = req_status_byte;
            taken.note = req_note_byte;
            taken.velocity = req_velocity_byte;
            taken.should_play = decide_play(req_status_byte, req_note_byte, req_velocity_byte);
            pending_decisions.push_back(taken);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("[midi_note_repeat_filter] ERROR");
      $finish;
   end

   // Leaves start high on return so that the next item can follow without a gap.
   task automatic send_note(input logic [7:0] status, input logic [7:0] note,
                            input logic [7:0] velocity);
      req_status_byte <= status;
      req_note_byte <= note;
      req_velocity_byte <= velocity;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic maybe_hold_off();
      if ($urandom_range(0, 4) == 0)
         hold_off($urandom_range(1, 12));
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_decisions.size() != 0) @(posedge clock);
   endtask

   task automatic write_filter_mode(input logic [1:0] mode);
      wait_drained();
      csr_write_en <= 1'b1;
      csr_write_data <= mode;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Most items press and release a few shared notes so that counts climb above one and
   // fall back to zero; the rest are stray notes and random statuses.
   task automatic send_random_note();
      int         pick;
      logic [3:0] channel;
      logic [7:0] pitch;
      logic [7:0] velocity;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 2))
         0:       channel = 4'h0;
         1:       channel = 4'hf;
         default: channel = 4'h9;
      endcase
      case ($urandom_range(0, 3))
         0:       pitch = 8'd0;
         1:       pitch = 8'd60;
         2:       pitch = 8'd61;
         default: pitch = 8'd127;
      endcase
      if (pick < 40) begin
         send_note({MSG_NOTE_ON, channel}, pitch, 8'($urandom_range(1, 127)));
      end else if (pick < 75) begin
         if ($urandom_range(0, 1) == 0) begin
            send_note({MSG_NOTE_OFF, channel}, pitch, 8'($urandom_range(0, 255)));
         end else begin
            velocity = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(128, 255));
            send_note({MSG_NOTE_ON, channel}, pitch, velocity);
         end
      end else if (pick < 88) begin
         send_note({($urandom_range(0, 1) == 0) ? MSG_NOTE_ON : MSG_NOTE_OFF,
                    4'($urandom_range(0, 15))},
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else begin
         send_note(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
      end
   endtask

   // Runs with the mode left at its reset value: note-offs pass only on the last release.
   task automatic test_reset_defaults();
      send_note(8'h90, 8'd60, 8'd100);
      send_note(8'h90, 8'd60, 8'd127);
      send_note(8'h80, 8'd60, 8'd0);
      send_note(8'h90, 8'd60, 8'd0);
      send_note(8'h80, 8'd60, 8'd64);
      send_note(8'h9f, 8'd127, 8'd1);
      send_note(8'h9f, 8'd127, 8'd255);
      send_note(8'h90, 8'd128, 8'd50);
      send_note(8'h8f, 8'd255, 8'd255);
      send_note(8'h90, 8'd0, 8'd128);
      send_note(8'h00, 8'd0, 8'd0);
      send_note(8'h7f, 8'd255, 8'd255);
      send_note(8'ha5, 8'd10, 8'd10);
      send_note(8'hff, 8'd0, 8'd255);
   endtask

   task automatic test_mode_repeats();
      write_filter_mode(2'd1);
      repeat (2) send_note(8'h93, 8'd64, 8'd90);
      repeat (2) send_note(8'h83, 8'd64, 8'd64);
      write_filter_mode(2'd3);
      repeat (2) send_note(8'h93, 8'd64, 8'd90);
      repeat (2) send_note(8'h83, 8'd64, 8'd64);
      write_filter_mode(2'd0);
      send_note(8'h93, 8'd64, 8'd90);
      send_note(8'h93, 8'd64, 8'd0);
   endtask

   // Halfway through each mode the sender stops until every result is back.
   task automatic test_random_modes();
      logic [1:0] modes [4];
      modes = '{2'd0, 2'd3, 2'd1, 2'd2};
      foreach (modes[m]) begin
         write_filter_mode(modes[m]);
         for (int n = 0; n < 400; n++) begin
            if (n == 200)
               wait_drained();
            maybe_hold_off();
            send_random_note();
         end
      end
   endtask

   task automatic test_back_to_back();
      write_filter_mode(2'($urandom_range(0, 3)));
      repeat (200) send_random_note();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_mode_repeats();
      test_random_modes();
      test_back_to_back();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_decisions.size() == 0) begin
         $display("[midi_note_repeat_filter] OK");
      end else begin
         foreach (pending_decisions[p]) begin
            $display("%0t: missing result, expected %0b, got none",
                     $time, pending_decisions[p].should_play);
         end
         $display("[midi_note_repeat_filter] ERROR");
      end
      $finish;
   end

endmodule
